// ===== design/positional_array_list_assert.svh =====
// ----------------------------------------------------------------------------
// positional_array_list assertion macros
// Shared property macros for the list checker.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_ARRAY_LIST_ASSERT_SVH
`define POSITIONAL_ARRAY_LIST_ASSERT_SVH

// Condition in the same cycle implies consequence in the same cycle.
`define PAL_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pal assertion failed");

// Condition in one cycle implies consequence in the next cycle.
`define PAL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pal assertion failed");

`endif

// ===== design/pal_pkg.sv =====
// ----------------------------------------------------------------------------
// pal_pkg
// Types and codes shared by the positional list cells, controller and checker.
// ----------------------------------------------------------------------------
`default_nettype none

package pal_pkg;

  // Number of list slots. The position, index and count fields below are sized
  // for this many entries.
  localparam int CAPACITY = 64;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_FIND   = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_FULL    = 2'd1,
    STS_RANGE   = 2'd2,
    STS_MISSING = 2'd3
  } status_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } state_e;

  typedef struct packed {
    cmd_e               command;
    logic [6:0]         position;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    status_e    status;
    logic [5:0] found_index;
    logic [6:0] element_count;
    logic       is_empty;
  } out_item_t;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic shift_up;
    logic shift_down;
    logic capture;
    logic scan;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== design/pal_cell.sv =====
// ----------------------------------------------------------------------------
// pal_cell
// One list slot: holds an entry and a match flag, trades both with neighbors.
// ----------------------------------------------------------------------------
`default_nettype none

module pal_cell #(
  parameter int IDX = 0,
  parameter int PW  = 7
) (
  input  wire                      clk,
  input  pal_pkg::cell_ctrl_t      ctrl,
  input  wire [PW-1:0]             pos,
  input  wire logic signed [31:0]  value,
  input  wire logic signed [31:0]  lower_data,
  input  wire logic signed [31:0]  upper_data,
  input  wire                      upper_flag,
  output logic signed [31:0]       data_o,
  output logic                     flag_o
);
  import pal_pkg::*;

  localparam logic [PW-1:0] MY_IDX = PW'(IDX);

  logic signed [31:0] data_r;
  logic signed [31:0] data_nxt;
  logic               flag_r;
  logic               flag_nxt;
  logic               above;
  logic               here;

  assign above = MY_IDX > pos;
  assign here  = MY_IDX == pos;

  always_comb begin
    data_nxt = data_r;
    if (ctrl.shift_up && above) begin
      data_nxt = lower_data;
    end else if (ctrl.shift_up && here) begin
      data_nxt = value;
    end else if (ctrl.shift_down && (above || here)) begin
      data_nxt = upper_data;
    end
  end

  // The match flags form a shift line toward slot zero during a search.
  always_comb begin
    flag_nxt = flag_r;
    if (ctrl.capture) begin
      flag_nxt = (data_r == value);
    end else if (ctrl.scan) begin
      flag_nxt = upper_flag;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    flag_r <= flag_nxt;
  end

  assign data_o = data_r;
  assign flag_o = flag_r;

endmodule

`default_nettype wire

// ===== design/pal_ctrl.sv =====
// ----------------------------------------------------------------------------
// pal_ctrl
// Command sequencer, entry count and result register for the positional list.
// ----------------------------------------------------------------------------
`default_nettype none

module pal_ctrl #(
  parameter int CAPACITY = 64,
  parameter int CW       = 7,
  parameter int PW       = 7
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_stall,
  input  pal_pkg::in_item_t     in_data,
  output logic                  out_valid,
  input  wire                   out_stall,
  output pal_pkg::out_item_t    out_data,
  output pal_pkg::cell_ctrl_t   cell_ctrl,
  output logic [PW-1:0]         cell_pos,
  input  wire                   head_flag
);
  import pal_pkg::*;

  state_e     state_r;
  state_e     state_nxt;
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic [CW-1:0] scan_idx_r;
  logic [CW-1:0] scan_idx_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  out_item_t  out_data_r;
  out_item_t  out_data_nxt;

  logic       slot_free;
  logic       accept;
  logic       full;
  logic       ins_ok;
  logic       rem_ok;
  logic       res_load;
  status_e    res_status;
  logic [5:0] res_index;
  logic [PW-1:0] cnt_w;

  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE) || !slot_free;
  assign accept    = in_valid && !in_stall;

  assign cell_pos = PW'(in_data.position);
  assign cnt_w    = PW'(count_r);
  assign full     = count_r == CW'(CAPACITY);
  assign ins_ok   = !full && (cell_pos <= cnt_w);
  assign rem_ok   = cell_pos < cnt_w;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && in_data.command == CMD_FIND) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_idx_r >= count_r || head_flag) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cell_ctrl    = '0;
    count_nxt    = count_r;
    scan_idx_nxt = scan_idx_r;
    res_load     = 1'b0;
    res_status   = STS_OK;
    res_index    = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_data.command)
            CMD_INSERT: begin
              res_load = 1'b1;
              if (full) begin
                res_status = STS_FULL;
              end else if (!ins_ok) begin
                res_status = STS_RANGE;
              end else begin
                cell_ctrl.shift_up = 1'b1;
                count_nxt          = count_r + 1'b1;
              end
            end
            CMD_REMOVE: begin
              res_load = 1'b1;
              if (!rem_ok) begin
                res_status = STS_RANGE;
              end else begin
                cell_ctrl.shift_down = 1'b1;
                count_nxt            = count_r - 1'b1;
              end
            end
            CMD_FIND: begin
              cell_ctrl.capture = 1'b1;
              scan_idx_nxt      = '0;
            end
            CMD_CLEAR: begin
              res_load  = 1'b1;
              count_nxt = '0;
            end
            default: begin
              res_load = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_idx_r >= count_r) begin
          res_load   = 1'b1;
          res_status = STS_MISSING;
        end else if (head_flag) begin
          res_load  = 1'b1;
          res_index = 6'(scan_idx_r);
        end else begin
          cell_ctrl.scan = 1'b1;
          scan_idx_nxt   = scan_idx_r + 1'b1;
        end
      end
      default: begin
        cell_ctrl = '0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (res_load) begin
      out_valid_nxt              = 1'b1;
      out_data_nxt.status        = res_status;
      out_data_nxt.found_index   = res_index;
      out_data_nxt.element_count = 7'(count_nxt);
      out_data_nxt.is_empty      = count_nxt == '0;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_idx_r <= scan_idx_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== design/positional_array_list.sv =====
// ----------------------------------------------------------------------------
// positional_array_list
// Bounded ordered list of 32-bit words held in a chain of shifting cells.
// ----------------------------------------------------------------------------
//   Channel   Ports                            Payload
//   input     in_valid, in_stall, in_data      command, position, value
//   result    out_valid, out_stall, out_data   status, found_index, count, empty
//
// Insert and remove shift the cells at and above the position at once; clear
// only zeroes the count. Find captures a match flag in each cell, then the flags
// walk down one slot per cycle to slot zero, until a hit or the count is passed.
// Reset clears the count, the sequencer and the result valid; cells keep data.
// A new item is taken only while idle and while the result register is free or
// being drained; a stalled result holds its value until transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_array_list (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  pal_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  wire                 out_stall,
  output pal_pkg::out_item_t  out_data
);
  import pal_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > 7) ? CW : 7;

  cell_ctrl_t          cell_ctrl;
  logic [PW-1:0]       cell_pos;
  logic signed [31:0]  cell_data [CAPACITY];
  logic                cell_flag [CAPACITY];

  pal_ctrl #(
    .CAPACITY (CAPACITY),
    .CW       (CW),
    .PW       (PW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cell_ctrl (cell_ctrl),
    .cell_pos  (cell_pos),
    .head_flag (cell_flag[0])
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [31:0] lower_d;
    logic signed [31:0] upper_d;
    logic               upper_f;

    if (i == 0) begin : g_bottom
      assign lower_d = in_data.value;
    end else begin : g_lower
      assign lower_d = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_top
      assign upper_d = cell_data[i];
      assign upper_f = 1'b0;
    end else begin : g_upper
      assign upper_d = cell_data[i+1];
      assign upper_f = cell_flag[i+1];
    end

    pal_cell #(
      .IDX (i),
      .PW  (PW)
    ) u_cell (
      .clk        (clk),
      .ctrl       (cell_ctrl),
      .pos        (cell_pos),
      .value      (in_data.value),
      .lower_data (lower_d),
      .upper_data (upper_d),
      .upper_flag (upper_f),
      .data_o     (cell_data[i]),
      .flag_o     (cell_flag[i])
    );
  end

endmodule

`default_nettype wire

// ===== design/pal_checker.sv =====
// ----------------------------------------------------------------------------
// pal_checker
// Port-level checks on the positional list, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "positional_array_list_assert.svh"

module pal_checker (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  input  wire                 in_stall,
  input  pal_pkg::in_item_t   in_data,
  input  wire                 out_valid,
  input  wire                 out_stall,
  input  pal_pkg::out_item_t  out_data
);
  import pal_pkg::*;

  `PAL_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
  `PAL_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(out_data))
  `PAL_ASSERT_IMPLY(a_empty_flag, clk, rst_n, out_valid, out_data.is_empty == (out_data.element_count == 7'd0))
  `PAL_ASSERT_IMPLY(a_miss_index, clk, rst_n, out_valid && (out_data.status == STS_MISSING || out_data.status == STS_FULL || out_data.status == STS_RANGE), out_data.found_index == 6'd0)
  `PAL_ASSERT_IMPLY(a_full_count, clk, rst_n, out_valid && out_data.status == STS_FULL, out_data.is_empty == 1'b0)

endmodule

bind positional_array_list pal_checker u_pal_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
